[sv/ptr_pkg.sv]
// ----------------------------------------------------------------------------
// ptr_pkg
// Shared constants for the programmable time relay: configuration register
// indexes, port and register widths and bit positions inside mode_flags.
// ----------------------------------------------------------------------------
package ptr_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_PERIODS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INACTIVE_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_CYCLES   = 3'd6;

    // register widths
    localparam int MODE_W  = 4;
    localparam int TICKS_W = 32;
    localparam int CNT_W   = 16;

    // mode_flags bit positions
    localparam int MODE_IN_POL    = 0;
    localparam int MODE_IDLE_LVL  = 1;
    localparam int MODE_IN_PULSE  = 2;
    localparam int MODE_OUT_PULSE = 3;

endpackage

[sv/programmable_time_relay.sv]
// ----------------------------------------------------------------------------
// programmable_time_relay
// Tick-driven time relay: arm, qualify the trigger input, delay, then hold
// the output active or play a train of active/inactive pulses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per timer tick:
//   the raw trigger level and a start request. Output channel
//   (o_out_valid / i_out_stall) returns one word per tick: relay pin level,
//   armed and running flags after that tick.
//   A word accepted at a clock edge is loaded into the result register at that
//   same edge and is valid on the outputs from the cycle after. One word is
//   taken per cycle while the receiver does not stall; all per-tick work is a
//   handful of counter steps done in a single pass between the state
//   registers and the result register.
//   When the receiver stalls with a result pending, o_in_stall rises in the
//   same cycle, the result holds and no new tick is taken.
//   The user writes configuration through i_cfg_we / i_cfg_idx / i_cfg_data
//   only while the block is idle (not enforced by the block); unknown indexes are ignored.
//   Synchronous reset clears the configuration and relay state registers and
//   empties the result register, whose data fields are not reset.
// ----------------------------------------------------------------------------
module programmable_time_relay #(
    parameter int TIME_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [ptr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ptr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // tick input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_input_level,
    input  logic                            i_start_req,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_relay_level,
    output logic                            o_armed,
    output logic                            o_running
);
    import ptr_pkg::*;

    typedef struct packed {
        logic                  done;
        logic                  busy;
        logic [TIME_BITS-1:0]  left;
    } t_tmr;

    typedef struct packed {
        logic                  done;
        logic                  busy;
        logic [COUNT_BITS-1:0] left;
    } t_cnt;

    // one step of the shared timer; a fresh phase loads its length first
    function automatic t_tmr tmr_step(input logic busy, input logic [TIME_BITS-1:0] left,
                                      input logic [TIME_BITS-1:0] len);
        t_tmr r;
        r.left = busy ? left : len;
        if (r.left != '0) begin
            r.left = r.left - TIME_BITS'(1);
        end
        r.done = (r.left == '0);
        r.busy = !r.done;
        return r;
    endfunction

    // one step of the shared period / cycle counter
    function automatic t_cnt cnt_step(input logic busy, input logic [COUNT_BITS-1:0] left,
                                      input logic [COUNT_BITS-1:0] total);
        t_cnt r;
        r.left = busy ? left : total;
        if (r.left != '0) begin
            r.left = r.left - COUNT_BITS'(1);
        end
        r.done = (r.left == '0);
        r.busy = !r.done;
        return r;
    endfunction

    // configuration registers
    logic [MODE_W-1:0]     r_mode;
    logic [TICKS_W-1:0]    r_in_period;
    logic [CNT_W-1:0]      r_in_periods;
    logic [TICKS_W-1:0]    r_delay;
    logic [TICKS_W-1:0]    r_active;
    logic [TICKS_W-1:0]    r_inactive;
    logic [CNT_W-1:0]      r_cycles;

    // relay state
    logic                  r_armed, n_armed;
    logic                  r_firing, n_firing;
    logic                  r_act_ph, n_act_ph;
    logic                  r_inact_ph, n_inact_ph;
    logic                  r_tmr_busy, n_tmr_busy;
    logic [TIME_BITS-1:0]  r_ticks_left, n_ticks_left;
    logic                  r_cnt_busy, n_cnt_busy;
    logic [COUNT_BITS-1:0] r_periods_left, n_periods_left;
    logic                  r_out_lvl, n_out_lvl;

    // result register
    logic                  r_out_valid;
    logic                  r_res_relay, n_res_relay;
    logic                  r_res_armed;
    logic                  r_res_running;

    logic                  in_accept;

    // handshake: take a tick whenever the result slot is free or drains now
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= '0;
            r_in_period  <= '0;
            r_in_periods <= '0;
            r_delay      <= '0;
            r_active     <= '0;
            r_inactive   <= '0;
            r_cycles     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE_FLAGS:     r_mode       <= i_cfg_data[MODE_W-1:0];
                REG_INPUT_PERIOD:   r_in_period  <= i_cfg_data[TICKS_W-1:0];
                REG_INPUT_PERIODS:  r_in_periods <= i_cfg_data[CNT_W-1:0];
                REG_DELAY_TICKS:    r_delay      <= i_cfg_data[TICKS_W-1:0];
                REG_ACTIVE_TICKS:   r_active     <= i_cfg_data[TICKS_W-1:0];
                REG_INACTIVE_TICKS: r_inactive   <= i_cfg_data[TICKS_W-1:0];
                REG_PULSE_CYCLES:   r_cycles     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // single-pass tick update
    always_comb begin
        logic active;
        logic do_fire;
        t_tmr tr;
        t_cnt cr;

        n_armed        = r_armed;
        n_firing       = r_firing;
        n_act_ph       = r_act_ph;
        n_inact_ph     = r_inact_ph;
        n_tmr_busy     = r_tmr_busy;
        n_ticks_left   = r_ticks_left;
        n_cnt_busy     = r_cnt_busy;
        n_periods_left = r_periods_left;
        n_out_lvl      = r_out_lvl;
        do_fire        = 1'b0;
        active         = (i_input_level == r_mode[MODE_IN_POL]);
        tr             = '0;
        cr             = '0;

        // start arms only an idle relay
        if (i_start_req && !r_armed && !r_firing) begin
            n_armed    = 1'b1;
            n_tmr_busy = 1'b0;
            n_cnt_busy = 1'b0;
        end

        // input qualification
        if (n_armed) begin
            if (!r_mode[MODE_IN_PULSE]) begin
                do_fire = active;
            end else if (active) begin
                if (COUNT_BITS'(r_in_periods) == '0) begin
                    do_fire = 1'b1;
                end else begin
                    tr = tmr_step(n_tmr_busy, n_ticks_left, TIME_BITS'(r_in_period));
                    n_tmr_busy   = tr.busy;
                    n_ticks_left = tr.left;
                    if (tr.done) begin
                        cr = cnt_step(n_cnt_busy, n_periods_left, COUNT_BITS'(r_in_periods));
                        n_cnt_busy     = cr.busy;
                        n_periods_left = cr.left;
                        do_fire        = cr.done;
                    end
                end
            end else if (n_tmr_busy) begin
                // drop mid-period discards the count
                n_tmr_busy = 1'b0;
                n_cnt_busy = 1'b0;
            end
        end

        if (do_fire) begin
            n_armed    = 1'b0;
            n_firing   = 1'b1;
            n_act_ph   = 1'b0;
            n_inact_ph = 1'b0;
            n_tmr_busy = 1'b0;
            n_cnt_busy = 1'b0;
        end

        // delay, then output phases; a phase that ends hands over in the same tick
        if (n_firing) begin
            if (!n_act_ph && !n_inact_ph) begin
                tr = tmr_step(n_tmr_busy, n_ticks_left, TIME_BITS'(r_delay));
                n_tmr_busy   = tr.busy;
                n_ticks_left = tr.left;
                if (tr.done) begin
                    n_out_lvl = 1'b1;
                    if (r_mode[MODE_OUT_PULSE]) begin
                        n_act_ph = 1'b1;
                    end else begin
                        n_firing = 1'b0;
                    end
                end
            end
            if (n_act_ph) begin
                tr = tmr_step(n_tmr_busy, n_ticks_left, TIME_BITS'(r_active));
                n_tmr_busy   = tr.busy;
                n_ticks_left = tr.left;
                if (tr.done) begin
                    n_out_lvl  = 1'b0;
                    n_act_ph   = 1'b0;
                    n_inact_ph = 1'b1;
                end
            end
            if (n_inact_ph) begin
                tr = tmr_step(n_tmr_busy, n_ticks_left, TIME_BITS'(r_inactive));
                n_tmr_busy   = tr.busy;
                n_ticks_left = tr.left;
                if (tr.done) begin
                    n_inact_ph = 1'b0;
                    cr = cnt_step(n_cnt_busy, n_periods_left, COUNT_BITS'(r_cycles));
                    n_cnt_busy     = cr.busy;
                    n_periods_left = cr.left;
                    if (cr.done) begin
                        n_firing  = 1'b0;
                        n_out_lvl = 1'b0;
                    end else begin
                        n_act_ph  = 1'b1;
                        n_out_lvl = 1'b1;
                    end
                end
            end
        end

        n_res_relay = n_out_lvl ^ r_mode[MODE_IDLE_LVL];
    end

    // state update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed        <= 1'b0;
            r_firing       <= 1'b0;
            r_act_ph       <= 1'b0;
            r_inact_ph     <= 1'b0;
            r_tmr_busy     <= 1'b0;
            r_ticks_left   <= '0;
            r_cnt_busy     <= 1'b0;
            r_periods_left <= '0;
            r_out_lvl      <= 1'b0;
        end else if (in_accept) begin
            r_armed        <= n_armed;
            r_firing       <= n_firing;
            r_act_ph       <= n_act_ph;
            r_inact_ph     <= n_inact_ph;
            r_tmr_busy     <= n_tmr_busy;
            r_ticks_left   <= n_ticks_left;
            r_cnt_busy     <= n_cnt_busy;
            r_periods_left <= n_periods_left;
            r_out_lvl      <= n_out_lvl;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res_relay   <= n_res_relay;
            r_res_armed   <= n_armed;
            r_res_running <= n_firing;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_relay_level = r_res_relay;
    assign o_armed       = r_res_armed;
    assign o_running     = r_res_running;

    // armed and running are exclusive
    a_armed_xor_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_armed && r_firing))
        else $error("relay armed and running at once");

    // output phases exist only while running
    a_phase_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act_ph || r_inact_ph) |-> r_firing)
        else $error("output phase outside of run");

    // never both output phases
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_act_ph && r_inact_ph))
        else $error("active and inactive phase together");

    // an accepted tick always yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted tick produced no result");

    // result word mirrors the state it was taken from
    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_res_armed == r_armed) && (r_res_running == r_firing))
        else $error("result flags disagree with relay state");

endmodule
